@@ rtl/ehmp_pkg.sv @@
// Shared types, register codes and constants of the EMA migration policy block.
package ehmp_pkg;

    localparam int RATE_W       = 32;
    localparam int COUNT_W      = 16;
    localparam int COUNT_FIELDS = 4;
    localparam int SCALE_W      = 15;
    localparam int INST_W       = COUNT_W + SCALE_W;

    localparam logic [8:0] WEIGHT_ONE = 9'd256;

    // Register indexes on the configuration port (byte address is four times the index).
    localparam logic [2:0] REG_RATE_SCALE       = 3'd0;
    localparam logic [2:0] REG_SMOOTHING_WEIGHT = 3'd1;
    localparam logic [2:0] REG_HYSTERESIS_RATIO = 3'd2;
    localparam logic [2:0] REG_MIN_RATE_GAP     = 3'd3;
    localparam logic [2:0] REG_MIN_FAULTS       = 3'd4;

    localparam logic [14:0] RST_RATE_SCALE       = 15'd512;
    localparam logic [8:0]  RST_SMOOTHING_WEIGHT = 9'd64;
    localparam logic [7:0]  RST_HYSTERESIS_RATIO = 8'd51;
    localparam logic [15:0] RST_MIN_RATE_GAP     = 16'd26;
    localparam logic [15:0] RST_MIN_FAULTS       = 16'd5;

    // Result status codes.
    localparam logic [1:0] STATUS_FEW     = 2'd0;
    localparam logic [1:0] STATUS_QUIET   = 2'd1;
    localparam logic [1:0] STATUS_KEPT    = 2'd2;
    localparam logic [1:0] STATUS_MIGRATE = 2'd3;

    typedef struct packed {
        logic [14:0] rate_scale;
        logic [8:0]  smoothing_weight;
        logic [7:0]  hysteresis_ratio;
        logic [15:0] min_rate_gap;
        logic [15:0] min_faults;
    } cfg_t;

    typedef struct packed {
        logic              found;
        logic [RATE_W-1:0] peak;
        logic [RATE_W-1:0] cur;
    } rate_res_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DECIDE
    } state_t;

endpackage

@@ rtl/ehmp_req_if.sv @@
// Request channel: one region's interval report.
interface ehmp_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  region_index;
    logic [15:0] total_faults;
    logic [15:0] count_device_0;
    logic [15:0] count_device_1;
    logic [15:0] count_device_2;
    logic [15:0] count_device_3;

    modport source (
        output valid, region_index, total_faults,
        output count_device_0, count_device_1, count_device_2, count_device_3,
        input  ready
    );
    modport sink (
        input  valid, region_index, total_faults,
        input  count_device_0, count_device_1, count_device_2, count_device_3,
        output ready
    );
endinterface

@@ rtl/ehmp_rsp_if.sv @@
// Response channel: policy decision for one request.
interface ehmp_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [1:0]  target_device;
    logic [31:0] peak_rate;
    logic        clear_counts;

    modport source (
        output valid, status, target_device, peak_rate, clear_counts,
        input  ready
    );
    modport sink (
        input  valid, status, target_device, peak_rate, clear_counts,
        output ready
    );
endinterface

@@ rtl/ehmp_cfg_regs.sv @@
// APB-style configuration register file.
module ehmp_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [4:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    output ehmp_pkg::cfg_t  cfg
);
    import ehmp_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate_scale       <= RST_RATE_SCALE;
            cfg_reg.smoothing_weight <= RST_SMOOTHING_WEIGHT;
            cfg_reg.hysteresis_ratio <= RST_HYSTERESIS_RATIO;
            cfg_reg.min_rate_gap     <= RST_MIN_RATE_GAP;
            cfg_reg.min_faults       <= RST_MIN_FAULTS;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_RATE_SCALE:       cfg_reg.rate_scale       <= pwdata[14:0];
                REG_SMOOTHING_WEIGHT: cfg_reg.smoothing_weight <= pwdata[8:0];
                REG_HYSTERESIS_RATIO: cfg_reg.hysteresis_ratio <= pwdata[7:0];
                REG_MIN_RATE_GAP:     cfg_reg.min_rate_gap     <= pwdata[15:0];
                REG_MIN_FAULTS:       cfg_reg.min_faults       <= pwdata[15:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_RATE_SCALE:       prdata = {17'd0, cfg_reg.rate_scale};
            REG_SMOOTHING_WEIGHT: prdata = {23'd0, cfg_reg.smoothing_weight};
            REG_HYSTERESIS_RATIO: prdata = {24'd0, cfg_reg.hysteresis_ratio};
            REG_MIN_RATE_GAP:     prdata = {16'd0, cfg_reg.min_rate_gap};
            REG_MIN_FAULTS:       prdata = {16'd0, cfg_reg.min_faults};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

@@ rtl/ehmp_rate_pipe.sv @@
// Rate memory with the per-device read, blend and write-back pipeline and peak tracking.
module ehmp_rate_pipe #(
    parameter int REGIONS = 256,
    parameter int DEVICES = 4,
    localparam int DW = (DEVICES > 1) ? $clog2(DEVICES) : 1,
    localparam int RATE_DEPTH = REGIONS * DEVICES,
    localparam int AW = (RATE_DEPTH > 1) ? $clog2(RATE_DEPTH) : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ehmp_pkg::cfg_t          cfg,
    input  logic                    start,
    input  logic [AW-1:0]           base,
    input  logic [ehmp_pkg::COUNT_FIELDS-1:0][ehmp_pkg::COUNT_W-1:0] counts,
    input  logic                    pref_valid,
    input  logic [DW-1:0]           pref_dev,
    input  logic                    clr_en,
    input  logic [AW-1:0]           clr_addr,
    output logic                    done,
    output ehmp_pkg::rate_res_t     res,
    output logic [DW-1:0]           peak_dev
);
    import ehmp_pkg::*;

    logic [RATE_W-1:0] rate_mem [RATE_DEPTH];
    logic [RATE_W-1:0] rate_rd_reg;

    logic              active_reg, active_next;
    logic [DW-1:0]     issue_d_reg, issue_d_next;
    logic [AW-1:0]     base_reg;
    logic [COUNT_FIELDS-1:0][COUNT_W-1:0] counts_reg;
    logic              s1_valid_reg;
    logic [DW-1:0]     s1_d_reg;
    logic [INST_W-1:0] s1_inst_reg, s1_inst_next;
    logic              s2_valid_reg;
    logic [DW-1:0]     s2_d_reg;
    logic [39:0]       s2_pnew_reg, s2_pnew_next;
    logic [40:0]       s2_pold_reg, s2_pold_next;

    logic              found_reg, found_next;
    logic [RATE_W-1:0] peak_reg, peak_next;
    logic [RATE_W-1:0] cur_reg, cur_next;
    logic [DW-1:0]     peak_dev_reg, peak_dev_next;

    logic [DW+1:0]      d_ext;
    logic [COUNT_W-1:0] cnt;
    logic [AW-1:0]      rd_addr;
    logic [8:0]         w;
    logic [8:0]         w_old;
    logic [40:0]        acc;
    logic [RATE_W-1:0]  blended;
    logic               mem_we;
    logic [AW-1:0]      wr_addr;
    logic [RATE_W-1:0]  wr_data;
    logic               last_issue;

    // Issue side: one device address and its scaled count per cycle.
    always_comb
    begin
        d_ext        = (DW + 2)'(issue_d_reg);
        cnt          = (32'(issue_d_reg) < COUNT_FIELDS) ? counts_reg[d_ext[1:0]] : '0;
        s1_inst_next = cnt * cfg.rate_scale;
        rd_addr      = base_reg + AW'(issue_d_reg);
        last_issue   = (issue_d_reg == DW'(DEVICES - 1));
        active_next  = active_reg;
        issue_d_next = issue_d_reg;
        if (start)
        begin
            active_next  = 1'b1;
            issue_d_next = '0;
        end
        else if (active_reg)
        begin
            issue_d_next = issue_d_reg + 1'b1;
            if (last_issue)
            begin
                active_next = 1'b0;
            end
        end
    end

    // Blend products: new rate weighted by w, stored rate by the complement.
    always_comb
    begin
        w            = (cfg.smoothing_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.smoothing_weight;
        w_old        = WEIGHT_ONE - w;
        s2_pnew_next = w * s1_inst_reg;
        s2_pold_next = w_old * rate_rd_reg;
    end

    // Round, saturate, write back and track the peak.
    always_comb
    begin
        acc     = 41'(s2_pnew_reg) + s2_pold_reg + 41'd128;
        blended = acc[40] ? '1 : acc[39:8];

        mem_we  = s2_valid_reg || clr_en;
        wr_addr = s2_valid_reg ? (base_reg + AW'(s2_d_reg)) : clr_addr;
        wr_data = s2_valid_reg ? blended : '0;

        found_next    = found_reg;
        peak_next     = peak_reg;
        cur_next      = cur_reg;
        peak_dev_next = peak_dev_reg;
        if (start)
        begin
            found_next    = 1'b0;
            peak_next     = '0;
            cur_next      = '0;
            peak_dev_next = '0;
        end
        else if (s2_valid_reg)
        begin
            // Strict compare in ascending device order keeps the lowest index on ties.
            if (blended > peak_reg)
            begin
                found_next    = 1'b1;
                peak_next     = blended;
                peak_dev_next = s2_d_reg;
            end
            if (pref_valid && (pref_dev == s2_d_reg))
            begin
                cur_next = blended;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            issue_d_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            peak_reg     <= '0;
            cur_reg      <= '0;
            peak_dev_reg <= '0;
        end
        else
        begin
            active_reg   <= active_next;
            issue_d_reg  <= issue_d_next;
            s1_valid_reg <= active_reg;
            s2_valid_reg <= s1_valid_reg;
            found_reg    <= found_next;
            peak_reg     <= peak_next;
            cur_reg      <= cur_next;
            peak_dev_reg <= peak_dev_next;
        end
    end

    // The request payload is only held at the accepting edge, so the counts are kept here.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            base_reg   <= base;
            counts_reg <= counts;
        end
        s1_d_reg    <= issue_d_reg;
        s1_inst_reg <= s1_inst_next;
        s2_d_reg    <= s1_d_reg;
        s2_pnew_reg <= s2_pnew_next;
        s2_pold_reg <= s2_pold_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rate_mem[wr_addr] <= wr_data;
        end
        if (active_reg)
        begin
            rate_rd_reg <= rate_mem[rd_addr];
        end
    end

    assign done     = s2_valid_reg && (s2_d_reg == DW'(DEVICES - 1));
    assign res      = '{found: found_reg, peak: peak_reg, cur: cur_reg};
    assign peak_dev = peak_dev_reg;

endmodule

@@ rtl/ema_hysteresis_migration_policy_unit.sv @@
// Top level: sequencer, preferred-device store, decision and response register.
//
//  channel | dir | handshake       | payload
//  req     | in  | valid / ready   | region_index, total_faults, count_device_0..3
//  rsp     | out | valid / ready   | status, target_device, peak_rate, clear_counts
//  apb     | in  | psel / penable  | paddr, pwdata, prdata (pready tied high)
//
// A request with enough faults makes one rate memory read per device, passes two pipeline
// stages to write back, and ends in the decision state. A request with too few faults
// goes straight to the decision state. After reset a clearing pass over all
// REGIONS * DEVICES rate entries (1024 by default) zeroes the rate memory and the
// preferred-device store; req.ready stays low until it ends.
// A new request is taken while the previous response waits on rsp.ready; the decision
// stalls only when the response register is still full.
module ema_hysteresis_migration_policy_unit #(
    parameter int REGIONS = 256,
    parameter int DEVICES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    ehmp_req_if.sink    req,
    ehmp_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ehmp_pkg::*;

    localparam int DW         = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int RW         = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int RATE_DEPTH = REGIONS * DEVICES;
    localparam int AW         = (RATE_DEPTH > 1) ? $clog2(RATE_DEPTH) : 1;

    cfg_t      cfg;
    rate_res_t res;
    logic [DW-1:0] peak_dev;
    logic          pipe_done;

    state_t        state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          few_reg;
    logic [RW-1:0] region_reg;
    logic [DW:0]   pref_rd_reg;

    logic [DW:0]   pref_mem [REGIONS];

    logic [RW-1:0] region_lut [256];
    logic [RW-1:0] region;
    logic [AW-1:0] base;
    logic          accept;
    logic          few;
    logic          start;
    logic          clr_en;
    logic          clr_last;
    logic          slot_free;
    logic          load_out;
    logic          pref_we;
    logic [RW-1:0] pref_wr_addr;
    logic [DW:0]   pref_wr_data;
    logic [COUNT_FIELDS-1:0][COUNT_W-1:0] counts;

    logic          pref_valid;
    logic [DW-1:0] pref_dev;
    logic [40:0]   lhs;
    logic [40:0]   rhs;
    logic [32:0]   cur_gap;
    logic          migrate;
    logic [DW+1:0] dev_ext;
    logic [1:0]    status_val;
    logic [1:0]    target_val;
    logic [31:0]   peak_val;
    logic          clear_val;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    status_reg;
    logic [1:0]    target_reg;
    logic [31:0]   peak_reg;
    logic          clear_reg;

    // Region index modulo REGIONS, worked out at elaboration.
    for (genvar g = 0; g < 256; g++)
    begin : g_region_lut
        assign region_lut[g] = RW'(g % REGIONS);
    end

    ehmp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign counts     = {req.count_device_3, req.count_device_2,
                         req.count_device_1, req.count_device_0};
    assign region     = region_lut[req.region_index];
    assign base       = AW'(AW'(region) * AW'(DEVICES));
    assign few        = (req.total_faults < cfg.min_faults);
    assign accept     = req.valid && req.ready;
    assign clr_last   = (clr_cnt_reg == AW'(RATE_DEPTH - 1));
    assign slot_free  = !out_valid_reg || rsp.ready;
    assign pref_valid = pref_rd_reg[DW];
    assign pref_dev   = pref_rd_reg[DW-1:0];

    ehmp_rate_pipe #(
        .REGIONS (REGIONS),
        .DEVICES (DEVICES)
    ) u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .start      (start),
        .base       (base),
        .counts     (counts),
        .pref_valid (pref_valid),
        .pref_dev   (pref_dev),
        .clr_en     (clr_en),
        .clr_addr   (clr_cnt_reg),
        .done       (pipe_done),
        .res        (res),
        .peak_dev   (peak_dev)
    );

    // Next state.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = few ? ST_DECIDE : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (pipe_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Decision on the finished rates.
    always_comb
    begin
        lhs     = {1'b0, res.peak, 8'd0};
        rhs     = res.cur * {1'b1, cfg.hysteresis_ratio};
        cur_gap = {1'b0, res.cur} + {17'd0, cfg.min_rate_gap};
        migrate = (lhs > rhs) && ({1'b0, res.peak} > cur_gap)
                  && !(pref_valid && (pref_dev == peak_dev));
        dev_ext = (DW + 2)'(peak_dev);

        status_val = STATUS_FEW;
        target_val = 2'd0;
        peak_val   = 32'd0;
        clear_val  = 1'b0;
        if (!few_reg)
        begin
            if (!res.found)
            begin
                status_val = STATUS_QUIET;
            end
            else
            begin
                target_val = dev_ext[1:0];
                peak_val   = res.peak;
                clear_val  = migrate;
                status_val = migrate ? STATUS_MIGRATE : STATUS_KEPT;
            end
        end
    end

    // State outputs.
    always_comb
    begin
        req.ready    = 1'b0;
        clr_en       = 1'b0;
        load_out     = 1'b0;
        pref_we      = 1'b0;
        pref_wr_addr = region_reg;
        pref_wr_data = {1'b1, peak_dev};
        case (state_reg)
            ST_CLEAR:
            begin
                clr_en       = 1'b1;
                pref_we      = (32'(clr_cnt_reg) < 32'(REGIONS));
                pref_wr_addr = clr_cnt_reg[RW-1:0];
                pref_wr_data = '0;
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_DECIDE:
            begin
                load_out = slot_free;
                pref_we  = slot_free && clear_val;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
        start = accept && !few;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            few_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                few_reg <= few;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            region_reg <= region;
        end
        if (load_out)
        begin
            status_reg <= status_val;
            target_reg <= target_val;
            peak_reg   <= peak_val;
            clear_reg  <= clear_val;
        end
    end

    // Preferred-device store: valid bit over the device index.
    always_ff @(posedge clk)
    begin
        if (pref_we)
        begin
            pref_mem[pref_wr_addr] <= pref_wr_data;
        end
        if (accept)
        begin
            pref_rd_reg <= pref_mem[region];
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.target_device = target_reg;
    assign rsp.peak_rate     = peak_reg;
    assign rsp.clear_counts  = clear_reg;

`ifndef ASSERT_OFF
    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_done |-> (state_reg == ST_RUN))
        else $error("rate pipeline finished outside the run state");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (state_reg == ST_RUN))
        else $error("evaluated request did not enter the run state");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |-> !load_out)
        else $error("pending response overwritten");

    a_clear_on_migrate: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.clear_counts == (rsp.status == STATUS_MIGRATE)))
        else $error("clear_counts disagrees with migrate status");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == STATUS_FEW || rsp.status == STATUS_QUIET))
        |-> (rsp.peak_rate == 32'd0 && rsp.target_device == 2'd0))
        else $error("non-evaluated response carries a device or rate");
`endif

endmodule

@@ tb/ema_hysteresis_migration_policy_unit_test.sv @@
// Self-checking testbench for the EMA migration policy unit with a built-in policy predictor.
`timescale 1ns / 100ps

module ema_hysteresis_migration_policy_unit_test;
    import ehmp_pkg::*;

    localparam int REGION_COUNT   = 256;
    localparam int DEVICE_COUNT   = 4;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int STALL_LIMIT    = 20000;

    typedef struct packed {
        logic [7:0]       region;
        logic [15:0]      total;
        logic [3:0][15:0] count;
    } region_report_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  target;
        logic [31:0] peak;
        logic        clear;
    } decision_t;

    // Mirrors the block's rate store, preferred devices and registers, and
    // queues the decision that each accepted request should produce.
    class policy_tracker;
        logic [14:0] rate_scale;
        logic [8:0]  weight;
        logic [7:0]  hyst_ratio;
        logic [15:0] rate_gap;
        logic [15:0] min_faults;
        logic [31:0] rates [REGION_COUNT * DEVICE_COUNT];
        logic [1:0]  pref_dev [REGION_COUNT];
        bit          pref_valid [REGION_COUNT];
        decision_t   pending_decisions [$];
        int          mismatches;
        int          decisions_seen;

        function new();
            rate_scale = RST_RATE_SCALE;
            weight     = RST_SMOOTHING_WEIGHT;
            hyst_ratio = RST_HYSTERESIS_RATIO;
            rate_gap   = RST_MIN_RATE_GAP;
            min_faults = RST_MIN_FAULTS;
            foreach (rates[i])
                rates[i] = '0;
            foreach (pref_dev[i])
            begin
                pref_dev[i]   = '0;
                pref_valid[i] = 1'b0;
            end
            mismatches     = 0;
            decisions_seen = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_RATE_SCALE:       rate_scale = value[14:0];
                REG_SMOOTHING_WEIGHT: weight     = value[8:0];
                REG_HYSTERESIS_RATIO: hyst_ratio = value[7:0];
                REG_MIN_RATE_GAP:     rate_gap   = value[15:0];
                REG_MIN_FAULTS:       min_faults = value[15:0];
                default: ;
            endcase
        endfunction

        function void note_report(region_report_t r);
            decision_t       d;
            logic [8:0]      w;
            longint unsigned acc;
            logic [31:0]     peak;
            logic [31:0]     cur;
            logic [1:0]      peak_dev;
            bit              found;
            bit              beats_ratio;
            bit              beats_gap;
            bit              same_dev;
            int              base;

            d = '0;
            if (r.total < min_faults)
            begin
                pending_decisions = {pending_decisions, d};
                return;
            end
            w        = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
            base     = int'(r.region) * DEVICE_COUNT;
            peak     = '0;
            peak_dev = '0;
            found    = 1'b0;
            for (int k = 0; k < DEVICE_COUNT; k++)
            begin
                acc = 64'(w) * 64'(r.count[k]) * 64'(rate_scale)
                    + 64'(WEIGHT_ONE - w) * 64'(rates[base + k]) + 64'd128;
                acc = acc >> 8;
                if (acc > 64'hFFFF_FFFF)
                    acc = 64'hFFFF_FFFF;
                rates[base + k] = acc[31:0];
                // Strictly greater, so the lowest device index wins a tie.
                if (rates[base + k] > peak)
                begin
                    peak     = rates[base + k];
                    peak_dev = 2'(k);
                    found    = 1'b1;
                end
            end
            if (!found)
            begin
                d.status = STATUS_QUIET;
                pending_decisions = {pending_decisions, d};
                return;
            end
            cur = pref_valid[r.region] ? rates[base + pref_dev[r.region]] : 32'd0;
            beats_ratio = (64'(peak) << 8) > 64'(cur) * (64'd256 + 64'(hyst_ratio));
            beats_gap   = 64'(peak) > 64'(cur) + 64'(rate_gap);
            same_dev    = pref_valid[r.region] && (pref_dev[r.region] == peak_dev);
            d.target = peak_dev;
            d.peak   = peak;
            if (beats_ratio && beats_gap && !same_dev)
            begin
                pref_dev[r.region]   = peak_dev;
                pref_valid[r.region] = 1'b1;
                d.status = STATUS_MIGRATE;
                d.clear  = 1'b1;
            end
            else
                d.status = STATUS_KEPT;
            pending_decisions = {pending_decisions, d};
        endfunction

        task report_mismatch(string field, logic [31:0] got_value, logic [31:0] want_value);
            mismatches++;
            $display("response %0d: %s is %0h, expected %0h",
                     decisions_seen, field, got_value, want_value);
        endtask

        task check_decision(decision_t got);
            decision_t want;

            decisions_seen++;
            if (pending_decisions.size() == 0)
            begin
                report_mismatch("unrequested response, status", 32'(got.status), '0);
                return;
            end
            want = pending_decisions.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.target !== want.target)
                report_mismatch("target_device", 32'(got.target), 32'(want.target));
            if (got.peak !== want.peak)
                report_mismatch("peak_rate", got.peak, want.peak);
            if (got.clear !== want.clear)
                report_mismatch("clear_counts", 32'(got.clear), 32'(want.clear));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ehmp_req_if req_ch ();
    ehmp_rsp_if rsp_ch ();

    policy_tracker tracker;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            holdoff_requests;
    int            holdoff_served;
    logic [1:0]    hot_dev [REGION_COUNT];

    ema_hysteresis_migration_policy_unit #(
        .REGIONS (REGION_COUNT),
        .DEVICES (DEVICE_COUNT)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // Responses are checked before requests are noted, so a response always
    // meets an expectation from an earlier request.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                tracker.check_decision({rsp_ch.status, rsp_ch.target_device,
                                        rsp_ch.peak_rate, rsp_ch.clear_counts});
            if (req_ch.valid && req_ch.ready)
                tracker.note_report({req_ch.region_index, req_ch.total_faults,
                                     req_ch.count_device_3, req_ch.count_device_2,
                                     req_ch.count_device_1, req_ch.count_device_0});
        end
    end

    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (holdoff_served != holdoff_requests)
            begin
                holdoff_served++;
                rsp_ch.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int quiet;

        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("ema_hysteresis_migration_policy_unit_test NOT OK");
        $finish;
    end

    function automatic region_report_t make_report(int region, int total,
                                                   int c0, int c1, int c2, int c3);
        region_report_t r;

        r.region   = 8'(region);
        r.total    = 16'(total);
        r.count[0] = 16'(c0);
        r.count[1] = 16'(c1);
        r.count[2] = 16'(c2);
        r.count[3] = 16'(c3);
        return r;
    endfunction

    // Most requests revisit a few regions with one dominant device, so the
    // averages build up and the hot device occasionally moves.
    function automatic region_report_t random_report();
        region_report_t r;
        logic [1:0]     hot;
        int             shape;

        shape    = $urandom_range(0, 99);
        r.region = ($urandom_range(0, 99) < 75) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        if ($urandom_range(0, 99) < 12)
            hot_dev[r.region] = 2'($urandom);
        hot = hot_dev[r.region];
        if (shape < 72)
        begin
            for (int k = 0; k < DEVICE_COUNT; k++)
                r.count[k] = 16'($urandom_range(0, 150));
            r.count[hot] = 16'($urandom_range(200, 3000));
            if (shape < 6)
                r.count[hot + 2'd1] = r.count[hot];
        end
        else if (shape < 82)
            r.count = '0;
        else
            r.count = {$urandom, $urandom};
        if ($urandom_range(0, 99) < 85)
            r.total = 16'($urandom_range(int'(tracker.min_faults), 65535));
        else
            r.total = 16'($urandom);
        return r;
    endfunction

    task automatic send_report(region_report_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.region_index   <= r.region;
        req_ch.total_faults   <= r.total;
        req_ch.count_device_0 <= r.count[0];
        req_ch.count_device_1 <= r.count[1];
        req_ch.count_device_2 <= r.count[2];
        req_ch.count_device_3 <= r.count[3];
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (tracker.pending_decisions.size() != 0);
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            send_report(random_report());
        req_ch.valid <= 1'b0;
        wait_drained();
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_register(idx, value);
        @(posedge clk);
    endtask

    task automatic program_policy(int scale, int weight, int hyst, int gap, int min_total);
        apb_write(REG_RATE_SCALE, 32'(scale));
        apb_write(REG_SMOOTHING_WEIGHT, 32'(weight));
        apb_write(REG_HYSTERESIS_RATIO, 32'(hyst));
        apb_write(REG_MIN_RATE_GAP, 32'(gap));
        apb_write(REG_MIN_FAULTS, 32'(min_total));
    endtask

    initial
    begin
        region_report_t opening [$];

        tracker          = new();
        holdoff_requests = 0;
        holdoff_served   = 0;
        send_idle_pct    = 19;
        recv_idle_pct    = 77;
        foreach (hot_dev[i])
            hot_dev[i] = 2'($urandom);

        rst_n                 <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        req_ch.valid          <= 1'b0;
        req_ch.region_index   <= '0;
        req_ch.total_faults   <= '0;
        req_ch.count_device_0 <= '0;
        req_ch.count_device_1 <= '0;
        req_ch.count_device_2 <= '0;
        req_ch.count_device_3 <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests under the reset register values.
        opening = {opening, make_report(0, 4, 1000, 1000, 1000, 1000)};
        opening = {opening, make_report(0, 0, 0, 0, 0, 0)};
        opening = {opening, make_report(0, 5, 0, 0, 0, 0)};
        opening = {opening, make_report(255, 65535, 65535, 65535, 65535, 65535)};
        opening = {opening, make_report(255, 65535, 65535, 65535, 65535, 65535)};
        opening = {opening, make_report(1, 10, 0, 0, 0, 1000)};
        for (int i = 0; i < 5; i++)
            opening = {opening, make_report(1, 10, 0, 0, 4000, 0)};
        opening = {opening, make_report(2, 7, 0, 500, 500, 0)};
        opening = {opening, make_report(170, 16'hAAAA, 16'hAAAA, 16'h5555, 16'hAAAA,
                                        16'h5555)};
        opening = {opening, make_report(85, 16'h5555, 16'h5555, 16'hAAAA, 16'h5555,
                                        16'hAAAA)};
        opening = {opening, make_report(3, 5, 1, 0, 0, 0)};
        opening = {opening, make_report(3, 5, 0, 0, 0, 0)};
        opening = {opening, make_report(4, 6, 0, 3, 0, 2)};
        foreach (opening[i])
            send_report(opening[i]);
        req_ch.valid <= 1'b0;
        wait_drained();

        program_policy(25600, 256, 0, 0, 0);
        run_random(300);
        program_policy(1, 0, 255, 65535, 65535);
        run_random(40);
        // A weight above one is clamped to one.
        program_policy(1000, 511, 255, 1000, 1);
        run_random(250);

        send_idle_pct = 77;
        recv_idle_pct = 19;
        for (int p = 0; p < 3; p++)
        begin
            program_policy($urandom_range(1, 25600),
                           ($urandom_range(0, 99) < 15) ? $urandom_range(257, 511)
                                                        : $urandom_range(8, 256),
                           $urandom_range(0, 255),
                           ($urandom_range(0, 99) < 10) ? 65535 : $urandom_range(0, 3000),
                           $urandom_range(0, 40));
            run_random(200);
        end

        // No idling, and one long response hold-off so the request side backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_policy(512, 64, 51, 26, 5);
        holdoff_requests++;
        run_random(250);

        repeat (20) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_decisions.size() == 0)
            $display("ema_hysteresis_migration_policy_unit_test OK");
        else
            $display("ema_hysteresis_migration_policy_unit_test NOT OK");
        $finish;
    end

endmodule
